### hw/rtl/csfp_pkg.sv
package csfp_pkg;

	localparam int unsigned ID_W    = 3;
	localparam int unsigned VALUE_W = 10;
	localparam int unsigned COUNT_W = 2;

	localparam int unsigned NUM_FIELDS_DEF       = 5;
	localparam int unsigned DIGITS_PER_FIELD_DEF = 3;

	localparam logic [7:0] START_BYTE = 8'h4D;  // 'M'
	localparam logic [7:0] COMMA_BYTE = 8'h2C;  // ','
	localparam logic [7:0] DIGIT_ZERO = 8'h30;  // '0'
	localparam logic [7:0] DIGIT_NINE = 8'h39;  // '9'

	typedef struct packed {
		logic [ID_W-1:0]    field_id;
		logic [VALUE_W-1:0] field_value;
		logic               frame_done;
	} result_t;

endpackage

### hw/rtl/charger_status_frame_parser.sv
// Charger status frame parser. Takes one received byte per transfer on rx_*
// and parses frames of the form "M,D000,C000,V000,T000,O000": it hunts for
// 'M', then for each field expects a comma, skips a tag byte and converts the
// leading ASCII digits of DIGITS_PER_FIELD bytes to a decimal value. Each
// completed field comes out on res_* with its index; the last field of a frame
// has frame_done set. A byte other than a comma where one is expected drops the
// frame. One byte is taken every cycle: the parse state updates in the same
// cycle as the transfer, and results pass through an output register backed by
// a one-entry skid stage, so rx_ready drops only while both are full.
module charger_status_frame_parser #(
	parameter int unsigned NUM_FIELDS       = csfp_pkg::NUM_FIELDS_DEF,
	parameter int unsigned DIGITS_PER_FIELD = csfp_pkg::DIGITS_PER_FIELD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [csfp_pkg::ID_W-1:0]     field_id,
	output logic [csfp_pkg::VALUE_W-1:0]  field_value,
	output logic                          frame_done
);

	logic               rx_fire;
	logic               emit;
	csfp_pkg::result_t  result;
	logic               out_valid_q;
	csfp_pkg::result_t  out_q;
	logic               skid_valid_q;
	csfp_pkg::result_t  skid_q;
	logic               out_free;

	assign rx_ready = !skid_valid_q;
	assign rx_fire  = rx_valid && rx_ready;
	assign out_free = !out_valid_q || res_ready;

	csfp_parser #(
		.NUM_FIELDS       (NUM_FIELDS),
		.DIGITS_PER_FIELD (DIGITS_PER_FIELD)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (rx_fire),
		.rx_byte (rx_byte),
		.emit    (emit),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (res_ready) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (rx_fire && emit) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (res_ready) begin
				out_q <= skid_q;
			end
		end else if (rx_fire && emit) begin
			if (out_free) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

	assign res_valid   = out_valid_q;
	assign field_id    = out_q.field_id;
	assign field_value = out_q.field_value;
	assign frame_done  = out_q.frame_done;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !res_ready))
		else $error("skid stage filled while the output register could take the result");

	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (field_id <= csfp_pkg::ID_W'(NUM_FIELDS - 1)))
		else $error("field index beyond the last field");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_done) |-> (field_id == csfp_pkg::ID_W'(NUM_FIELDS - 1)))
		else $error("frame end flagged on a field other than the last");
`endif

endmodule

### hw/rtl/csfp_parser.sv
module csfp_parser #(
	parameter int unsigned NUM_FIELDS       = csfp_pkg::NUM_FIELDS_DEF,
	parameter int unsigned DIGITS_PER_FIELD = csfp_pkg::DIGITS_PER_FIELD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	output logic               emit,
	output csfp_pkg::result_t  result
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_COMMA,
		PH_TAG,
		PH_DIGITS
	} phase_t;

	localparam logic [csfp_pkg::ID_W-1:0]    LAST_IDX   = csfp_pkg::ID_W'(NUM_FIELDS - 1);
	localparam logic [csfp_pkg::COUNT_W-1:0] DIGITS_CNT =
		csfp_pkg::COUNT_W'(DIGITS_PER_FIELD);

	phase_t                          phase_q;
	logic [csfp_pkg::ID_W-1:0]       index_q;
	logic [csfp_pkg::COUNT_W-1:0]    count_q;
	logic [csfp_pkg::VALUE_W-1:0]    acc_q;
	logic                            still_q;

	logic                            is_digit;
	logic [csfp_pkg::VALUE_W+3:0]    mac;
	logic [csfp_pkg::VALUE_W-1:0]    acc_next;
	logic                            still_next;
	logic [csfp_pkg::COUNT_W-1:0]    count_inc;
	logic                            last_field;

	assign is_digit = (rx_byte >= csfp_pkg::DIGIT_ZERO) && (rx_byte <= csfp_pkg::DIGIT_NINE);

	// acc * 10 + digit; the low nibble of an ASCII digit is its value
	assign mac = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{(csfp_pkg::VALUE_W){1'b0}}, rx_byte[3:0]};

	assign still_next = still_q && is_digit;
	assign acc_next   = still_next ? mac[csfp_pkg::VALUE_W-1:0] : acc_q;
	assign count_inc  = count_q + 1'b1;
	assign last_field = (index_q >= LAST_IDX);

	assign emit               = (phase_q == PH_DIGITS) && (count_inc == DIGITS_CNT);
	assign result.field_id    = index_q;
	assign result.field_value = acc_next;
	assign result.frame_done  = last_field;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			index_q <= '0;
			count_q <= '0;
			acc_q   <= '0;
			still_q <= 1'b1;
		end else if (step) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == csfp_pkg::START_BYTE) begin
						phase_q <= PH_COMMA;
						index_q <= '0;
					end
				end
				PH_COMMA: begin
					if (rx_byte == csfp_pkg::COMMA_BYTE) begin
						phase_q <= PH_TAG;
					end else begin
						// drop the frame, the offending byte is consumed
						phase_q <= PH_HUNT;
						index_q <= '0;
						count_q <= '0;
						acc_q   <= '0;
						still_q <= 1'b1;
					end
				end
				PH_TAG: begin
					phase_q <= PH_DIGITS;
					count_q <= '0;
					acc_q   <= '0;
					still_q <= 1'b1;
				end
				PH_DIGITS: begin
					if (emit) begin
						phase_q <= last_field ? PH_HUNT : PH_COMMA;
						index_q <= last_field ? '0 : index_q + 1'b1;
						count_q <= '0;
						acc_q   <= '0;
						still_q <= 1'b1;
					end else begin
						count_q <= count_inc;
						acc_q   <= acc_next;
						still_q <= still_next;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule
